[rtl/core/wsq_pkg.sv]
// wsq_pkg: shared types and constants for the work-stealing task queues.
// Holds the beat structs, controller states and controller/datapath links.
// No dependencies; used by wsq_ctrl, wsq_dp and work_stealing_task_queues.
package wsq_pkg;

    localparam int CFG_W = 4;
    localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    typedef struct packed {
        logic        op;
        logic [2:0]  requester;
        logic [15:0] task_handle;
    } wsq_item_t;

    typedef struct packed {
        logic [15:0] out_task;
        logic        found;
        logic        stolen;
        logic [2:0]  queue_used;
        logic        rejected;
    } wsq_result_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PUSH_SCAN,
        S_POP_OWN,
        S_POP_STEAL,
        S_COMMIT,
        S_DONE
    } wsq_state_t;

    typedef struct packed {
        logic capture;
        logic advance;
        logic take_push;
        logic take_own;
        logic take_steal;
        logic commit;
        logic out_load;
    } wsq_cmd_t;

    typedef struct packed {
        logic new_pop;
        logic req_ok;
        logic idx_last;
        logic cnt_nz;
        logic better;
        logic at_home;
        logic out_free;
    } wsq_status_t;

endpackage

[rtl/core/wsq_ctrl.sv]
// wsq_ctrl: sequencing state machine for the work-stealing task queues.
// Walks the queue scan for a push or steal, then commit if taken, and load.
// Depends on wsq_pkg.
module wsq_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  wsq_pkg::wsq_status_t status,
    output wsq_pkg::wsq_cmd_t    cmd
);

    wsq_pkg::wsq_state_t state_reg;
    wsq_pkg::wsq_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= wsq_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            wsq_pkg::S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = status.new_pop ? wsq_pkg::S_POP_OWN : wsq_pkg::S_PUSH_SCAN;
                end
            end
            wsq_pkg::S_PUSH_SCAN:
            begin
                if (status.idx_last)
                begin
                    state_next = wsq_pkg::S_COMMIT;
                end
            end
            wsq_pkg::S_POP_OWN:
            begin
                if (!status.req_ok)
                begin
                    state_next = wsq_pkg::S_DONE;
                end
                else if (status.cnt_nz)
                begin
                    state_next = wsq_pkg::S_COMMIT;
                end
                else
                begin
                    state_next = wsq_pkg::S_POP_STEAL;
                end
            end
            wsq_pkg::S_POP_STEAL:
            begin
                if (status.at_home)
                begin
                    state_next = wsq_pkg::S_DONE;
                end
                else if (status.cnt_nz)
                begin
                    state_next = wsq_pkg::S_COMMIT;
                end
            end
            wsq_pkg::S_COMMIT:
            begin
                state_next = wsq_pkg::S_DONE;
            end
            wsq_pkg::S_DONE:
            begin
                if (status.out_free)
                begin
                    state_next = wsq_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = wsq_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        req_stall = 1'b1;
        unique case (state_reg)
            wsq_pkg::S_IDLE:
            begin
                req_stall   = 1'b0;
                cmd.capture = req_valid;
            end
            wsq_pkg::S_PUSH_SCAN:
            begin
                cmd.advance   = 1'b1;
                cmd.take_push = status.better;
            end
            wsq_pkg::S_POP_OWN:
            begin
                cmd.take_own = status.req_ok & status.cnt_nz;
                cmd.advance  = status.req_ok & ~status.cnt_nz;
            end
            wsq_pkg::S_POP_STEAL:
            begin
                cmd.take_steal = ~status.at_home & status.cnt_nz;
                cmd.advance    = ~status.at_home & ~status.cnt_nz;
            end
            wsq_pkg::S_COMMIT:
            begin
                cmd.commit = 1'b1;
            end
            wsq_pkg::S_DONE:
            begin
                cmd.out_load = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

[rtl/core/wsq_dp.sv]
// wsq_dp: datapath of the work-stealing task queues.
// Queue pointers and counts, task store, scan index, result register.
// Depends on wsq_pkg; driven by wsq_ctrl.
module wsq_dp #(
    parameter int MAX_THREADS = 8,
    parameter int QUEUE_DEPTH = 16,
    parameter int TASK_BITS   = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  wsq_pkg::wsq_item_t         req_data,
    input  logic                       cfg_we,
    input  logic [wsq_pkg::CFG_W-1:0]  cfg_wdata,
    input  wsq_pkg::wsq_cmd_t          cmd,
    output wsq_pkg::wsq_status_t       status,
    output logic                       rsp_valid,
    input  logic                       rsp_stall,
    output wsq_pkg::wsq_result_t       rsp_data
);

    localparam int ThreadW = $clog2(MAX_THREADS);
    localparam int NumW    = $clog2(MAX_THREADS + 1);
    localparam int LiveW   = (NumW > wsq_pkg::CFG_W) ? NumW : wsq_pkg::CFG_W;
    localparam int PtrW    = $clog2(QUEUE_DEPTH);
    localparam int CntW    = $clog2(QUEUE_DEPTH + 1);
    localparam int Entries = MAX_THREADS * QUEUE_DEPTH;
    localparam int AddrW   = $clog2(Entries);
    localparam int IdxW    = (ThreadW > 3) ? ThreadW : 3;
    localparam int WideW   = (TASK_BITS > 16) ? TASK_BITS : 16;

    logic [wsq_pkg::CFG_W-1:0] active_reg;
    logic                      op_reg;
    logic [2:0]                req_reg;
    logic [TASK_BITS-1:0]      handle_reg;
    logic [ThreadW-1:0]        idx_reg;
    logic [ThreadW-1:0]        tgt_reg;
    logic [CntW-1:0]           tgt_cnt_reg;
    logic                      found_reg;
    logic                      stolen_reg;
    logic [PtrW-1:0]           head_reg [MAX_THREADS];
    logic [PtrW-1:0]           tail_reg [MAX_THREADS];
    logic [CntW-1:0]           cnt_reg  [MAX_THREADS];
    logic [TASK_BITS-1:0]      mem      [Entries];
    logic [TASK_BITS-1:0]      mem_rd_reg;
    logic                      out_valid_reg;
    wsq_pkg::wsq_result_t      out_reg;

    logic                      out_valid_next;
    wsq_pkg::wsq_result_t      out_next;
    logic [PtrW-1:0]           head_next;
    logic [PtrW-1:0]           tail_next;
    logic [CntW-1:0]           cnt_next;

    logic [LiveW-1:0]          cfg_w;
    logic [LiveW-1:0]          max_w;
    logic [LiveW-1:0]          live;
    logic [LiveW-1:0]          idx_w;
    logic [LiveW-1:0]          req_w;
    logic [IdxW-1:0]           req_wide;
    logic [ThreadW-1:0]        req_idx;
    logic [ThreadW-1:0]        next_idx;
    logic [ThreadW-1:0]        a_q;
    logic [CntW-1:0]           cur_cnt;
    logic [PtrW-1:0]           cur_head;
    logic [PtrW-1:0]           cur_tail;
    logic                      full;
    logic                      push_ok;
    logic                      pop_go;
    logic [PtrW-1:0]           head_inc;
    logic [PtrW-1:0]           tail_inc;
    logic [PtrW-1:0]           tail_dec;
    logic [AddrW-1:0]          base;
    logic [PtrW-1:0]           slot;
    logic [AddrW-1:0]          addr;
    logic [WideW-1:0]          handle_wide;
    logic [WideW-1:0]          rd_wide;
    logic [IdxW-1:0]           tgt_wide;

    function automatic logic [ThreadW-1:0] req_data_idx(input logic [2:0] r);
        logic [IdxW-1:0] w;
        w = IdxW'(r);
        return w[ThreadW-1:0];
    endfunction

    // effective thread count: 0 acts as 1, clamp at MAX_THREADS
    assign cfg_w = LiveW'(active_reg);
    assign max_w = LiveW'(MAX_THREADS);
    assign live  = (cfg_w == '0) ? LiveW'(1) : ((cfg_w > max_w) ? max_w : cfg_w);

    assign idx_w    = LiveW'(idx_reg);
    assign req_w    = LiveW'(req_reg);
    assign req_wide = IdxW'(req_reg);
    assign req_idx  = req_wide[ThreadW-1:0];
    assign next_idx = (idx_w == live - LiveW'(1)) ? '0 : idx_reg + ThreadW'(1);

    assign a_q      = cmd.commit ? tgt_reg : idx_reg;
    assign cur_cnt  = cnt_reg[a_q];
    assign cur_head = head_reg[a_q];
    assign cur_tail = tail_reg[a_q];

    assign full     = tgt_cnt_reg >= CntW'(QUEUE_DEPTH);
    assign push_ok  = cmd.commit & (op_reg == wsq_pkg::OP_PUSH) & ~full;
    assign pop_go   = cmd.commit & (op_reg == wsq_pkg::OP_POP);

    assign head_inc = (cur_head == PtrW'(QUEUE_DEPTH - 1)) ? '0 : cur_head + PtrW'(1);
    assign tail_inc = (cur_tail == PtrW'(QUEUE_DEPTH - 1)) ? '0 : cur_tail + PtrW'(1);
    assign tail_dec = (cur_tail == '0) ? PtrW'(QUEUE_DEPTH - 1) : cur_tail - PtrW'(1);

    assign head_next = head_inc;
    assign tail_next = (op_reg == wsq_pkg::OP_PUSH) ? tail_inc : tail_dec;
    assign cnt_next  = (op_reg == wsq_pkg::OP_PUSH) ? cur_cnt + CntW'(1)
                                                    : cur_cnt - CntW'(1);

    // front of own queue, back of a victim, or back slot on push
    always_comb
    begin
        if (op_reg == wsq_pkg::OP_PUSH)
        begin
            slot = cur_tail;
        end
        else if (stolen_reg)
        begin
            slot = tail_dec;
        end
        else
        begin
            slot = cur_head;
        end
    end

    assign base = AddrW'(tgt_reg) * AddrW'(QUEUE_DEPTH);
    assign addr = base + AddrW'(slot);

    assign handle_wide = WideW'(req_data.task_handle);
    assign rd_wide     = WideW'(mem_rd_reg);
    assign tgt_wide    = IdxW'(tgt_reg);

    assign status.new_pop  = (req_data.op == wsq_pkg::OP_POP);
    assign status.req_ok   = req_w < live;
    assign status.idx_last = (idx_w == live - LiveW'(1));
    assign status.cnt_nz   = (cur_cnt != '0);
    assign status.better   = (idx_reg == '0) || (cur_cnt < tgt_cnt_reg);
    assign status.at_home  = (idx_reg == req_idx);
    assign status.out_free = ~out_valid_reg | ~rsp_stall;

    always_comb
    begin
        out_next.out_task   = found_reg ? rd_wide[15:0] : 16'd0;
        out_next.found      = found_reg;
        out_next.stolen     = stolen_reg;
        out_next.queue_used = ((op_reg == wsq_pkg::OP_PUSH) || found_reg) ? tgt_wide[2:0]
                                                                          : req_reg;
        out_next.rejected   = (op_reg == wsq_pkg::OP_PUSH) & full;
    end

    always_comb
    begin
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= wsq_pkg::CFG_RESET;
            out_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
            stolen_reg    <= 1'b0;
            for (int i = 0; i < MAX_THREADS; i++)
            begin
                head_reg[i] <= '0;
                tail_reg[i] <= '0;
                cnt_reg[i]  <= '0;
            end
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                active_reg <= cfg_wdata;
            end
            if (cmd.capture)
            begin
                found_reg  <= 1'b0;
                stolen_reg <= 1'b0;
            end
            if (cmd.take_own)
            begin
                found_reg <= 1'b1;
            end
            if (cmd.take_steal)
            begin
                found_reg  <= 1'b1;
                stolen_reg <= 1'b1;
            end
            if (push_ok || pop_go)
            begin
                cnt_reg[tgt_reg] <= cnt_next;
            end
            if (push_ok || (pop_go && stolen_reg))
            begin
                tail_reg[tgt_reg] <= tail_next;
            end
            if (pop_go && !stolen_reg)
            begin
                head_reg[tgt_reg] <= head_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg     <= req_data.op;
            req_reg    <= req_data.requester;
            handle_reg <= handle_wide[TASK_BITS-1:0];
            idx_reg    <= (req_data.op == wsq_pkg::OP_POP) ? req_data_idx(req_data.requester)
                                                           : '0;
        end
        else if (cmd.advance)
        begin
            idx_reg <= next_idx;
        end
        if (cmd.take_push || cmd.take_own || cmd.take_steal)
        begin
            tgt_reg     <= idx_reg;
            tgt_cnt_reg <= cur_cnt;
        end
        if (cmd.out_load)
        begin
            out_reg <= out_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            mem[addr] <= handle_reg;
        end
        if (pop_go)
        begin
            mem_rd_reg <= mem[addr];
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp_data  = out_reg;

endmodule

[rtl/core/work_stealing_task_queues.sv]
// work_stealing_task_queues: top level of the per-thread task queue block.
// Joins the wsq_ctrl state machine and the wsq_dp datapath.
// Depends on wsq_pkg, wsq_ctrl, wsq_dp.
//
// Usage:
//   req channel (req_valid/req_stall/req_data): one beat is a push of
//   task_handle (op = push) or a pop for thread requester (op = pop).
//   rsp channel (rsp_valid/rsp_stall/rsp_data): one result beat per request.
//   cfg_we/cfg_wdata set active_threads; write only while the block is idle.
// Sequence (n = active thread count after clamping):
//   push: a scan over the counts of all n active queues, then one commit and
//   one load that registers the result.
//   pop: a check of the own queue, up to n - 1 steal probes plus a final
//   wrap check, a commit with the task store read only when a task is found,
//   and one load; an inactive requester goes straight to the load.
//   One request is in flight at a time; req_stall drops the cycle after the
//   result is loaded, so the next request overlaps a stalled result beat.
// The scan walks the per-queue counts one queue a cycle; the task store has
// a single port used at most once per request.
// Reset: all queues empty, active_threads = 8, no result pending. The task
// store itself is not cleared. A stalled rsp beat holds and the block waits
// in its load state until the beat is taken.
module work_stealing_task_queues #(
    parameter int MAX_THREADS = 8,
    parameter int QUEUE_DEPTH = 16,
    parameter int TASK_BITS   = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      req_valid,
    output logic                      req_stall,
    input  wsq_pkg::wsq_item_t        req_data,
    output logic                      rsp_valid,
    input  logic                      rsp_stall,
    output wsq_pkg::wsq_result_t      rsp_data,
    input  logic                      cfg_we,
    input  logic [wsq_pkg::CFG_W-1:0] cfg_wdata
);

    wsq_pkg::wsq_cmd_t    cmd;
    wsq_pkg::wsq_status_t status;

    wsq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .status    (status),
        .cmd       (cmd)
    );

    wsq_dp #(
        .MAX_THREADS (MAX_THREADS),
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .TASK_BITS   (TASK_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_data  (req_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .status    (status),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data)
    );

endmodule

[verif/work_stealing_task_queues_tb.sv]
// work_stealing_task_queues_tb: self-checking bench for the per-thread task queues.
// Predicts shortest-queue push and own-front/steal-back pop with active-thread changes.
// Depends on wsq_pkg and work_stealing_task_queues.
module work_stealing_task_queues_tb;

    localparam int NUM_QUEUES  = 8;
    localparam int QUEUE_SLOTS = 16;
    localparam int SETTLE_CYCLES = 20;
    localparam int HOLD_AT_BEAT = 900;
    localparam int HOLD_CYCLES  = 400;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      req_valid = 1'b0;
    logic                      req_stall;
    wsq_pkg::wsq_item_t        req_data = '0;
    logic                      rsp_valid;
    logic                      rsp_stall = 1'b0;
    wsq_pkg::wsq_result_t      rsp_data;
    logic                      cfg_we = 1'b0;
    logic [wsq_pkg::CFG_W-1:0] cfg_wdata = '0;

    logic             calm = 1'b0;
    int               err_count = 0;
    int               rsp_beats = 0;
    int               hold_left = 0;
    bit               hold_done = 1'b0;

    wsq_pkg::wsq_item_t   pending_items[$];
    wsq_pkg::wsq_result_t expected_results[$];

    // Shadow of the queue state
    logic [15:0]      shadow_store[NUM_QUEUES][QUEUE_SLOTS];
    int               shadow_head[NUM_QUEUES];
    int               shadow_tail[NUM_QUEUES];
    int               shadow_count[NUM_QUEUES];
    int               shadow_threads = 8;

    work_stealing_task_queues DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #3000000;
        $display("work_stealing_task_queues_tb: FAIL");
        $finish;
    end

    function automatic wsq_pkg::wsq_result_t schedule_task(wsq_pkg::wsq_item_t it);
        wsq_pkg::wsq_result_t r;
        int n;
        int best;
        int v;
        int i;
        r = '0;
        n = (shadow_threads == 0) ? 1 :
            (shadow_threads > NUM_QUEUES) ? NUM_QUEUES : shadow_threads;
        if (it.op == wsq_pkg::OP_PUSH)
        begin
            best = 0;
            for (i = 1; i < n; i++)
                if (shadow_count[i] < shadow_count[best])
                    best = i;
            r.queue_used = best[2:0];
            if (shadow_count[best] >= QUEUE_SLOTS)
                r.rejected = 1'b1;
            else
            begin
                shadow_store[best][shadow_tail[best]] = it.task_handle;
                shadow_tail[best] = (shadow_tail[best] + 1) % QUEUE_SLOTS;
                shadow_count[best]++;
            end
        end
        else
        begin
            r.queue_used = it.requester;
            if (int'(it.requester) < n)
            begin
                v = it.requester;
                if (shadow_count[v] != 0)
                begin
                    r.out_task = shadow_store[v][shadow_head[v]];
                    shadow_head[v] = (shadow_head[v] + 1) % QUEUE_SLOTS;
                    shadow_count[v]--;
                    r.found = 1'b1;
                end
                else
                begin
                    for (i = 1; i < n; i++)
                    begin
                        v = (it.requester + i) % n;
                        if (shadow_count[v] != 0)
                        begin
                            shadow_tail[v] = (shadow_tail[v] + QUEUE_SLOTS - 1) % QUEUE_SLOTS;
                            shadow_count[v]--;
                            r.out_task = shadow_store[v][shadow_tail[v]];
                            r.found = 1'b1;
                            r.stolen = 1'b1;
                            r.queue_used = v[2:0];
                            break;
                        end
                    end
                end
            end
        end
        return r;
    endfunction

    // Request driver
    always @(posedge clk)
    begin
        if (!rst_n)
            req_valid <= 1'b0;
        else
        begin
            if (req_valid && !req_stall)
                expected_results.push_back(schedule_task(req_data));
            if (!req_valid || !req_stall)
            begin
                if (pending_items.size() != 0 && (calm || $urandom_range(0, 99) >= 19))
                begin
                    req_valid <= 1'b1;
                    req_data  <= pending_items.pop_front();
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    // Result monitor and receiver stall
    always @(posedge clk)
    begin
        wsq_pkg::wsq_result_t exp_rsp;
        int next_hold;
        next_hold = hold_left;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            rsp_beats++;
            if (expected_results.size() == 0)
            begin
                err_count++;
                $display("%0t: unexpected result beat %h", $time, rsp_data);
            end
            else
            begin
                exp_rsp = expected_results.pop_front();
                if (rsp_data !== exp_rsp)
                begin
                    err_count++;
                    $display("%0t: mismatch exp %h/%b/%b/%0d/%b got %h/%b/%b/%0d/%b",
                             $time, exp_rsp.out_task, exp_rsp.found, exp_rsp.stolen,
                             exp_rsp.queue_used, exp_rsp.rejected, rsp_data.out_task,
                             rsp_data.found, rsp_data.stolen, rsp_data.queue_used,
                             rsp_data.rejected);
                end
            end
            if (rsp_beats == HOLD_AT_BEAT && !hold_done)
            begin
                hold_done = 1'b1;
                next_hold = HOLD_CYCLES;
            end
        end
        if (next_hold > 0)
        begin
            rsp_stall <= 1'b1;
            hold_left <= next_hold - 1;
        end
        else
            rsp_stall <= calm ? 1'b0 : ($urandom_range(0, 99) < 19);
    end

    task automatic add_item(input logic op, input logic [2:0] requester,
                            input logic [15:0] handle);
        wsq_pkg::wsq_item_t it;
        it.op = op;
        it.requester = requester;
        it.task_handle = handle;
        pending_items.push_back(it);
    endtask

    task automatic settle();
        while (pending_items.size() != 0 || req_valid || expected_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_threads(input logic [wsq_pkg::CFG_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        shadow_threads = value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(negedge clk);
    endtask

    task automatic random_phase(input int pct_push, input int count);
        int k;
        int pick;
        logic [15:0] handle;
        for (k = 0; k < count; k++)
        begin
            pick = $urandom_range(0, 15);
            handle = (pick == 0) ? 16'h0000 : (pick == 1) ? 16'hFFFF :
                     16'($urandom_range(0, 65535));
            add_item(($urandom_range(0, 99) < pct_push) ? wsq_pkg::OP_PUSH : wsq_pkg::OP_POP,
                     3'($urandom_range(0, 7)), handle);
        end
    endtask

    initial
    begin
        int phase_cfg[12] = '{0, 15, 3, 8, 2, 5, 1, 12, 7, 4, 8, 6};
        int phase_pct[12] = '{80, 40, 85, 95, 50, 30, 70, 60, 55, 90, 20, 50};
        int p;
        int k;
        for (k = 0; k < NUM_QUEUES; k++)
        begin
            shadow_head[k] = 0;
            shadow_tail[k] = 0;
            shadow_count[k] = 0;
        end
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset setting: empty pop, shortest-queue pushes, own pop, steals with wrap
        add_item(wsq_pkg::OP_POP,  3'd0, 16'h1234);
        add_item(wsq_pkg::OP_PUSH, 3'd5, 16'hFFFF);
        add_item(wsq_pkg::OP_PUSH, 3'd7, 16'h0000);
        add_item(wsq_pkg::OP_PUSH, 3'd0, 16'h8001);
        add_item(wsq_pkg::OP_POP,  3'd0, 16'hFFFF);
        add_item(wsq_pkg::OP_POP,  3'd0, 16'h0000);
        add_item(wsq_pkg::OP_POP,  3'd7, 16'h5A5A);
        settle();

        // Single queue: fill, reject when full, inactive requester, own pop
        write_threads(4'd1);
        for (k = 0; k < QUEUE_SLOTS + 1; k++)
            add_item(wsq_pkg::OP_PUSH, 3'(k), 16'(k * 16'h0F0F));
        add_item(wsq_pkg::OP_POP, 3'd3, 16'h0000);
        add_item(wsq_pkg::OP_POP, 3'd0, 16'h0000);
        settle();

        for (p = 0; p < 12; p++)
        begin
            write_threads(4'(phase_cfg[p]));
            calm <= (p == 3);
            random_phase(phase_pct[p], 150);
            settle();
        end
        calm <= 1'b0;
        settle();

        if (err_count == 0)
            $display("work_stealing_task_queues_tb: PASS");
        else
            $display("work_stealing_task_queues_tb: FAIL");
        $finish;
    end
endmodule

[filelist.f]
rtl/core/wsq_pkg.sv
rtl/core/wsq_ctrl.sv
rtl/core/wsq_dp.sv
rtl/core/work_stealing_task_queues.sv
verif/work_stealing_task_queues_tb.sv
